### rtl/core/pcud_pkg.sv
// pcud_pkg: shared types, constants and pixel reconstruction for the dequantizer
// no dependencies
package pcud_pkg;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);
  localparam int unsigned WinBits   = 15;  // up to seven held bits plus one byte
  localparam int unsigned WinCntW   = 4;

  localparam logic [3:0] CodeBitsReset = 4'd8;

  // one queued byte as seen by the back end
  typedef struct packed {
    logic                vld;
    logic [ByteBits-1:0] data;
  } q_head_t;

  // effective code length: zero reads as one, above eight reads as eight
  function automatic logic [3:0] eff_len(input logic [3:0] code_bits);
    logic [3:0] len;
    if (code_bits == 4'd0) begin
      len = 4'd1;
    end else if (code_bits > 4'd8) begin
      len = 4'd8;
    end else begin
      len = code_bits;
    end
    return len;
  endfunction

  // take the len bits just below window position n, top-align, add half step
  function automatic logic [7:0] recon(input logic [WinBits-1:0] win,
                                       input logic [WinCntW-1:0] n,
                                       input logic [3:0] len);
    logic [WinBits-1:0] al;
    logic [7:0]         keep;
    logic [7:0]         val;
    al   = win << (4'd15 - n);
    keep = ~(8'hFF >> len);
    val  = al[WinBits-1 -: 8] & keep;
    if (len < 4'd8) begin
      val = val | (8'h80 >> len);
    end
    return val;
  endfunction

endpackage

### rtl/core/pcud_front.sv
// pcud_front: input acceptance and short byte queue ahead of the unpacker
// depends on pcud_pkg
module pcud_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pcud_pkg::ByteBits-1:0] packed_byte_i,
  output pcud_pkg::q_head_t             head_o,
  input  logic                          pop_i
);

  logic [pcud_pkg::ByteBits-1:0] mem_q [pcud_pkg::QueueDepth];
  logic [pcud_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [pcud_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [pcud_pkg::QCntW-1:0]    cnt_q, cnt_d;
  logic                          push;
  logic                          pop;

  // queue status
  assign in_ready_o  = (cnt_q != pcud_pkg::QCntW'(pcud_pkg::QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_i && (cnt_q != '0);
  assign head_o.vld  = (cnt_q != '0);
  assign head_o.data = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pcud_pkg::QPtrW'(pcud_pkg::QueueDepth - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pcud_pkg::QPtrW'(pcud_pkg::QueueDepth - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // byte storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= packed_byte_i;
    end
  end

endmodule

### rtl/core/pcud_back.sv
// pcud_back: bit window unpacker, code length register and pixel output register
// depends on pcud_pkg
module pcud_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [3:0]        code_bits_i,
  input  pcud_pkg::q_head_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        pixel_value_o,
  output logic              last_of_byte_o
);

  logic [3:0]                      code_bits_q;
  logic [pcud_pkg::WinBits-1:0]    win_q, win_d;
  logic [pcud_pkg::WinCntW-1:0]    n_q, n_d;
  logic                            out_valid_q;
  logic [7:0]                      pixel_q;
  logic                            last_q;
  logic [3:0]                      len;
  logic                            have_code;
  logic                            can_emit;
  logic [pcud_pkg::WinCntW-1:0]    n_rem;
  logic [pcud_pkg::WinCntW-1:0]    rem;
  logic                            byte_done;
  logic                            pop;

  assign len       = pcud_pkg::eff_len(code_bits_q);
  assign have_code = (n_q >= len);
  assign can_emit  = have_code && (!out_valid_q || out_ready_i);
  assign n_rem     = n_q - len;
  assign byte_done = (n_rem < len);
  assign rem       = can_emit ? n_rem : n_q;
  // load the next byte as soon as the current one has no whole code left
  assign pop       = head_i.vld && (can_emit ? byte_done : !have_code);
  assign pop_o     = pop;

  // window update
  always_comb begin
    win_d = win_q;
    n_d   = rem;
    if (pop) begin
      win_d = {win_q[6:0], head_i.data};
      n_d   = rem + pcud_pkg::WinCntW'(pcud_pkg::ByteBits);
    end
    if (cfg_valid_i) begin
      n_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= pcud_pkg::CodeBitsReset;
      n_q         <= '0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        code_bits_q <= code_bits_i;
      end
      n_q   <= n_d;
      win_q <= win_d;
      if (can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (can_emit) begin
      pixel_q <= pcud_pkg::recon(win_q, n_q, len);
      last_q  <= byte_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = pixel_q;
  assign last_of_byte_o = last_q;

endmodule

### rtl/core/packed_code_uniform_dequantizer_top.sv
// path: a taken byte passes the byte queue, the bit window and the pixel output register
// throughput: one pixel per cycle from the unpacker while the output is ready; a byte yields
//   floor((held bits + 8) / code length) pixels, eight pixels with one-bit codes
// reset: queue empty, no held bits, code length eight, output not valid
// depends on pcud_pkg, pcud_front, pcud_back
module packed_code_uniform_dequantizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] code_bits_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] packed_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pixel_value_o,
  output logic       last_of_byte_o
);

  pcud_pkg::q_head_t head;
  logic              pop;
  logic              cfg_we;

  // configuration beats are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // byte queue
  pcud_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .packed_byte_i (packed_byte_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  // unpacker and output
  pcud_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_we),
    .code_bits_i    (code_bits_i),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .last_of_byte_o (last_of_byte_o)
  );

endmodule
